FILE: rtl/core/pqed_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pqed_pkg;

  // Input item as it arrives on the request port.
  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] timestamp;
    logic [5:0]  channel;
    logic [15:0] level_a;
    logic [15:0] level_b;
    logic        appliance_on;
  } request_t;

  // Result item as it leaves on the result port.
  typedef struct packed {
    logic        event_valid;
    logic [2:0]  event_kind;
    logic [1:0]  event_phase;
    logic [15:0] event_severity;
    logic [9:0]  event_duration_ms;
    logic [31:0] event_time;
  } result_t;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_VOLTAGE   = 2'd0,
    OP_FLICKER   = 2'd1,
    OP_APPLIANCE = 2'd2,
    OP_POP       = 2'd3
  } op_t;

  // Event kinds as recorded in the ring.
  typedef enum logic [2:0] {
    KIND_INTERRUPTION = 3'd0,
    KIND_SAG          = 3'd1,
    KIND_SWELL        = 3'd2,
    KIND_HARMONIC     = 3'd3,
    KIND_FLICKER      = 3'd4,
    KIND_ON           = 3'd5,
    KIND_OFF          = 3'd6
  } kind_t;

  // Configuration register indexes and port widths.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_60HZ  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_THD_LIMIT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PST_LIMIT  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_S = 2'd3;

  localparam logic [15:0] THD_LIMIT_RESET  = 16'd800;
  localparam logic [15:0] PST_LIMIT_RESET  = 16'd100;
  localparam logic [15:0] DEBOUNCE_S_RESET = 16'd2;

  // Configuration as seen by the front end.
  typedef struct packed {
    logic        grid_60hz;
    logic [15:0] thd_limit;
    logic [15:0] pst_limit;
    logic [15:0] debounce_s;
  } cfg_t;

  // Nominal voltages in centivolts and the thresholds on ten times the RMS value.
  localparam logic [15:0] NOM_50HZ_CV   = 16'd23000;
  localparam logic [15:0] NOM_60HZ_CV   = 16'd12000;
  localparam logic [19:0] SAG_THR_50HZ   = 20'd207000;
  localparam logic [19:0] SWELL_THR_50HZ = 20'd253000;
  localparam logic [19:0] SAG_THR_60HZ   = 20'd108000;
  localparam logic [19:0] SWELL_THR_60HZ = 20'd132000;

  localparam logic [5:0]  PHASE_MAX        = 6'd2;
  localparam logic [1:0]  PHASE_AGGREGATE  = 2'd3;
  localparam logic [9:0]  DURATION_QUALITY = 10'd1000;
  localparam logic [15:0] SEVERITY_MAX     = 16'hFFFF;

  // Deviation in hundredths of a percent is diff * 10000 / nominal, which is
  // diff * 10 / 23 at 230 V and diff * 5 / 6 at 120 V. The division runs as a
  // multiplication by a truncated reciprocal followed by one correction step.
  localparam int PCT_RECIP_SHIFT = 24;
  localparam int PCT_RECIP_W     = 22;
  localparam int PCT_NUM_W       = 20;
  localparam int PCT_PROD_W      = PCT_NUM_W + PCT_RECIP_W;
  localparam int PCT_DIV_W       = 5;
  localparam logic [PCT_DIV_W-1:0] PCT_DIV_50HZ = 5'd23;
  localparam logic [PCT_DIV_W-1:0] PCT_DIV_60HZ = 5'd6;
  localparam logic [PCT_RECIP_W-1:0] PCT_RECIP_50HZ =
    PCT_RECIP_W'((64'd1 << PCT_RECIP_SHIFT) / 64'd23);
  localparam logic [PCT_RECIP_W-1:0] PCT_RECIP_60HZ =
    PCT_RECIP_W'((64'd1 << PCT_RECIP_SHIFT) / 64'd6);

  // Command passed from the front end to the back end.
  typedef struct packed {
    logic        is_pop;
    kind_t       kind;
    logic [1:0]  phase;
    logic [15:0] value;
    logic        pct;
    logic        grid_60hz;
    logic [31:0] stamp;
  } cmd_t;

  // One stored event; the duration follows from the kind.
  typedef struct packed {
    kind_t       kind;
    logic [1:0]  phase;
    logic [15:0] severity;
    logic [31:0] stamp;
  } entry_t;

  // Command queue between the two ends.
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef struct packed {
    logic empty;
    logic full;
    logic room2;
  } cmdq_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/pqed_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pqed_ram #(
  parameter int WIDTH = 53,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/pqed_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module pqed_cmd_fifo (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire pqed_pkg::cmd_t         push_cmd,
  input  wire logic                   pop,
  output pqed_pkg::cmd_t              head,
  output pqed_pkg::cmdq_status_t      status
);

  pqed_pkg::cmd_t                       slots [pqed_pkg::CMDQ_DEPTH];
  logic [pqed_pkg::CMDQ_PTR_W-1:0]      wr_ptr;
  logic [pqed_pkg::CMDQ_PTR_W-1:0]      rd_ptr;
  logic [pqed_pkg::CMDQ_CNT_W-1:0]      count;

  // Pointers and fill count; the depth is a power of two, so pointers wrap freely.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Command storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  assign head         = slots[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == pqed_pkg::CMDQ_CNT_W'(pqed_pkg::CMDQ_DEPTH));
  assign status.room2 = (count <= pqed_pkg::CMDQ_CNT_W'(pqed_pkg::CMDQ_DEPTH - 2));

endmodule

`default_nettype wire

FILE: rtl/core/pqed_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pqed_front #(
  parameter int NUM_CLASSES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire pqed_pkg::request_t request,
  input  wire pqed_pkg::cfg_t     cfg,
  output logic                    idle,
  output logic                    push,
  output pqed_pkg::cmd_t          push_cmd
);

  localparam int CLASS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  typedef enum logic [1:0] {
    F_IDLE,
    F_EVAL,
    F_SECOND
  } state_t;

  state_t               state;
  pqed_pkg::request_t   item_q;

  logic                 reported [NUM_CLASSES];
  logic [31:0]          stamp    [NUM_CLASSES];

  pqed_pkg::op_t        op;
  logic                 phase_ok;
  logic                 class_ok;
  logic [CLASS_W-1:0]   idx;
  logic [15:0]          nom;
  logic [19:0]          sag_thr;
  logic [19:0]          swell_thr;
  logic [19:0]          v10;
  logic                 below_int;
  logic                 below_sag;
  logic                 above_swell;
  logic                 volt_hit;
  logic                 thd_hit;
  logic                 changed;
  logic                 settled;
  logic [31:0]          elapsed;
  logic                 eval_valid;
  logic                 need_second;
  pqed_pkg::cmd_t       eval_cmd;
  pqed_pkg::cmd_t       thd_cmd;

  // Classification of the held item.
  always_comb begin
    op        = pqed_pkg::op_t'(item_q.operation);
    phase_ok  = (item_q.channel <= pqed_pkg::PHASE_MAX);
    class_ok  = ({1'b0, item_q.channel} < 7'(NUM_CLASSES));
    idx       = item_q.channel[CLASS_W-1:0];
    nom       = cfg.grid_60hz ? pqed_pkg::NOM_60HZ_CV : pqed_pkg::NOM_50HZ_CV;
    sag_thr   = cfg.grid_60hz ? pqed_pkg::SAG_THR_60HZ : pqed_pkg::SAG_THR_50HZ;
    swell_thr = cfg.grid_60hz ? pqed_pkg::SWELL_THR_60HZ : pqed_pkg::SWELL_THR_50HZ;
    v10       = ({4'b0, item_q.level_a} << 3) + ({4'b0, item_q.level_a} << 1);

    below_int   = (v10 < {4'b0, nom});
    below_sag   = (v10 < sag_thr);
    above_swell = (v10 > swell_thr);
    volt_hit    = phase_ok && (below_sag || above_swell);
    thd_hit     = phase_ok && (item_q.level_b > cfg.thd_limit);

    changed = (item_q.appliance_on != reported[idx]);
    elapsed = item_q.timestamp - stamp[idx];
    settled = (elapsed >= {16'b0, cfg.debounce_s});

    // Fields common to every event of this item.
    eval_cmd           = '0;
    eval_cmd.phase     = item_q.channel[1:0];
    eval_cmd.grid_60hz = cfg.grid_60hz;
    eval_cmd.stamp     = item_q.timestamp;
    eval_cmd.value     = item_q.level_a;
    eval_valid         = 1'b0;

    thd_cmd       = eval_cmd;
    thd_cmd.kind  = pqed_pkg::KIND_HARMONIC;
    thd_cmd.value = item_q.level_b;

    unique case (op)
      pqed_pkg::OP_VOLTAGE: begin
        if (volt_hit) begin
          eval_valid = 1'b1;
          if (below_int) begin
            eval_cmd.kind = pqed_pkg::KIND_INTERRUPTION;
          end else if (below_sag) begin
            eval_cmd.kind  = pqed_pkg::KIND_SAG;
            eval_cmd.value = nom - item_q.level_a;
            eval_cmd.pct   = 1'b1;
          end else begin
            eval_cmd.kind  = pqed_pkg::KIND_SWELL;
            eval_cmd.value = item_q.level_a - nom;
            eval_cmd.pct   = 1'b1;
          end
        end else if (thd_hit) begin
          eval_valid = 1'b1;
          eval_cmd   = thd_cmd;
        end
      end
      pqed_pkg::OP_FLICKER: begin
        eval_valid    = phase_ok && (item_q.level_a > cfg.pst_limit);
        eval_cmd.kind = pqed_pkg::KIND_FLICKER;
      end
      pqed_pkg::OP_APPLIANCE: begin
        eval_valid     = class_ok && changed && settled;
        eval_cmd.kind  = item_q.appliance_on ? pqed_pkg::KIND_ON : pqed_pkg::KIND_OFF;
        eval_cmd.phase = pqed_pkg::PHASE_AGGREGATE;
      end
      pqed_pkg::OP_POP: begin
        eval_valid      = 1'b1;
        eval_cmd.is_pop = 1'b1;
      end
      default: begin
        eval_valid = 1'b0;
      end
    endcase

    need_second = (op == pqed_pkg::OP_VOLTAGE) && volt_hit && thd_hit;
  end

  // Sequencer: take an item, emit its first command, then the THD command if due.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            state  <= F_EVAL;
            item_q <= request;
          end
        end
        F_EVAL: begin
          state <= need_second ? F_SECOND : F_IDLE;
        end
        F_SECOND: begin
          state <= F_IDLE;
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  // Appliance class table: debounced state and the time it was last confirmed.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        reported[i] <= 1'b0;
        stamp[i]    <= '0;
      end
    end else if (state == F_EVAL && op == pqed_pkg::OP_APPLIANCE && class_ok) begin
      if (!changed) begin
        stamp[idx] <= item_q.timestamp;
      end else if (settled) begin
        reported[idx] <= item_q.appliance_on;
        stamp[idx]    <= item_q.timestamp;
      end
    end
  end

  assign idle     = (state == F_IDLE);
  assign push     = ((state == F_EVAL) && eval_valid) || (state == F_SECOND);
  assign push_cmd = (state == F_SECOND) ? thd_cmd : eval_cmd;

endmodule

`default_nettype wire

FILE: rtl/core/pqed_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pqed_back #(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  input  wire pqed_pkg::cmd_t  cmd,
  output logic                 take,
  output logic                 done,
  output pqed_pkg::result_t    result
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam int QUO_W = pqed_pkg::PCT_PROD_W - pqed_pkg::PCT_RECIP_SHIFT;
  localparam int REM_W = QUO_W + pqed_pkg::PCT_DIV_W;

  typedef enum logic [1:0] {
    B_IDLE,
    B_PCT,
    B_READ
  } state_t;

  state_t                               state;
  logic [PTR_W-1:0]                     write_ptr;
  logic [PTR_W-1:0]                     read_ptr;
  pqed_pkg::cmd_t                       cmd_q;
  logic [pqed_pkg::PCT_NUM_W-1:0]       num_q;
  logic [pqed_pkg::PCT_PROD_W-1:0]      prod_q;

  logic [pqed_pkg::PCT_NUM_W-1:0]       num;
  logic [pqed_pkg::PCT_RECIP_W-1:0]     recip;
  logic [pqed_pkg::PCT_PROD_W-1:0]      prod_next;
  logic [QUO_W-1:0]                     quo0;
  logic [pqed_pkg::PCT_DIV_W-1:0]       divisor;
  logic [REM_W-1:0]                     rem;
  logic [QUO_W:0]                       quo;
  logic [15:0]                          pct_sev;

  logic                                 ram_we;
  pqed_pkg::entry_t                     ram_wentry;
  logic [$bits(pqed_pkg::entry_t)-1:0]  ram_rdata;
  pqed_pkg::entry_t                     rd_entry;
  logic                                 enqueue;
  logic [PTR_W-1:0]                     write_ptr_inc;
  logic [PTR_W-1:0]                     read_ptr_inc;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // First step of the percentage: scale the deviation and multiply by the reciprocal.
  always_comb begin
    if (cmd.grid_60hz) begin
      num   = ({4'b0, cmd.value} << 2) + {4'b0, cmd.value};
      recip = pqed_pkg::PCT_RECIP_60HZ;
    end else begin
      num   = ({4'b0, cmd.value} << 3) + ({4'b0, cmd.value} << 1);
      recip = pqed_pkg::PCT_RECIP_50HZ;
    end
    prod_next = pqed_pkg::PCT_PROD_W'(num) * pqed_pkg::PCT_PROD_W'(recip);
  end

  // Second step: the estimate is at most one short, so one compare corrects it.
  always_comb begin
    divisor = cmd_q.grid_60hz ? pqed_pkg::PCT_DIV_60HZ : pqed_pkg::PCT_DIV_50HZ;
    quo0    = prod_q[pqed_pkg::PCT_PROD_W-1:pqed_pkg::PCT_RECIP_SHIFT];
    rem     = REM_W'(num_q) - (REM_W'(quo0) * REM_W'(divisor));
    quo     = {1'b0, quo0} + ((rem >= REM_W'(divisor)) ? 1'b1 : 1'b0);
    pct_sev = (quo > (QUO_W + 1)'(pqed_pkg::SEVERITY_MAX)) ?
              pqed_pkg::SEVERITY_MAX : quo[15:0];
  end

  // Ring writes: plain events straight from the queue head, percentages in the following cycle.
  always_comb begin
    take       = (state == B_IDLE) && cmd_valid;
    ram_wentry = '0;
    ram_we     = 1'b0;
    if (state == B_PCT) begin
      ram_we              = 1'b1;
      ram_wentry.kind     = cmd_q.kind;
      ram_wentry.phase    = cmd_q.phase;
      ram_wentry.severity = pct_sev;
      ram_wentry.stamp    = cmd_q.stamp;
    end else if (take && !cmd.is_pop && !cmd.pct) begin
      ram_we              = 1'b1;
      ram_wentry.kind     = cmd.kind;
      ram_wentry.phase    = cmd.phase;
      ram_wentry.severity = cmd.value;
      ram_wentry.stamp    = cmd.stamp;
    end
    enqueue       = ram_we;
    write_ptr_inc = wrap_inc(write_ptr);
    read_ptr_inc  = wrap_inc(read_ptr);
  end

  pqed_ram #(
    .WIDTH ($bits(pqed_pkg::entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_ptr),
    .wdata (ram_wentry),
    .raddr (read_ptr),
    .rdata (ram_rdata)
  );

  assign rd_entry = pqed_pkg::entry_t'(ram_rdata);

  // Back-end sequencer, ring pointers and the registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      write_ptr <= '0;
      read_ptr  <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;

      // A full ring drops its oldest event to make room.
      if (enqueue) begin
        write_ptr <= write_ptr_inc;
        if (write_ptr_inc == read_ptr) begin
          read_ptr <= read_ptr_inc;
        end
      end

      unique case (state)
        B_IDLE: begin
          if (take) begin
            if (cmd.is_pop) begin
              if (read_ptr == write_ptr) begin
                done   <= 1'b1;
                result <= '0;
              end else begin
                read_ptr <= read_ptr_inc;
                state    <= B_READ;
              end
            end else if (cmd.pct) begin
              cmd_q  <= cmd;
              num_q  <= num;
              prod_q <= prod_next;
              state  <= B_PCT;
            end
          end
        end
        B_PCT: begin
          state <= B_IDLE;
        end
        B_READ: begin
          done                     <= 1'b1;
          result.event_valid       <= 1'b1;
          result.event_kind        <= rd_entry.kind;
          result.event_phase       <= rd_entry.phase;
          result.event_severity    <= rd_entry.severity;
          result.event_duration_ms <=
            (rd_entry.kind == pqed_pkg::KIND_ON || rd_entry.kind == pqed_pkg::KIND_OFF) ?
            '0 : pqed_pkg::DURATION_QUALITY;
          result.event_time        <= rd_entry.stamp;
          state                    <= B_IDLE;
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/power_quality_event_detector.sv
`timescale 1ns / 1ps
`default_nettype none

// Power quality event detector for one phase per item.
// An item is transferred on request when start is high and busy is low. Voltage
// and flicker checks and appliance updates record events in an internal ring of
// QUEUE_DEPTH-1 entries that drops its oldest event when full; a pop item reads
// out the oldest event. Only a pop gives a result: done is high for exactly one
// cycle with the result fields, and event_valid is low on an empty ring.
// The receiver cannot stall; each result must be taken in its done cycle.
// The front end holds an item through its evaluation state, and through a
// second state for a voltage check that raises both a voltage and a THD
// event, and takes no new item until it is through; busy also rises while the
// four-entry command queue cannot take two more commands. The back end writes
// a sag or swell through an extra state for the two-step percentage multiply,
// and a pop result is registered in the back end's read state, or as the pop
// is taken on an empty ring. Configuration writes take effect at the next edge and belong to
// idle periods. Synchronous reset empties the ring and clears the appliance
// table; the ring storage itself is not cleared, so no clearing pass is needed.
module power_quality_event_detector #(
  parameter int QUEUE_DEPTH = 32,
  parameter int NUM_CLASSES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire pqed_pkg::request_t                request,
  output logic                                   done,
  output pqed_pkg::result_t                      result,
  input  wire logic                              cfg_we,
  input  wire logic [pqed_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [pqed_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pqed_pkg::cfg_t          cfg;
  logic                    accept;
  logic                    front_idle;
  logic                    cmd_push;
  pqed_pkg::cmd_t          cmd_in;
  pqed_pkg::cmd_t          cmd_head;
  pqed_pkg::cmdq_status_t  q_status;
  logic                    cmd_take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_60hz  <= 1'b0;
      cfg.thd_limit  <= pqed_pkg::THD_LIMIT_RESET;
      cfg.pst_limit  <= pqed_pkg::PST_LIMIT_RESET;
      cfg.debounce_s <= pqed_pkg::DEBOUNCE_S_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pqed_pkg::CFG_GRID_60HZ:  cfg.grid_60hz  <= cfg_data[0];
        pqed_pkg::CFG_THD_LIMIT:  cfg.thd_limit  <= cfg_data;
        pqed_pkg::CFG_PST_LIMIT:  cfg.pst_limit  <= cfg_data;
        pqed_pkg::CFG_DEBOUNCE_S: cfg.debounce_s <= cfg_data;
        default:                  cfg.grid_60hz  <= cfg.grid_60hz;
      endcase
    end
  end

  // Transfer when the front end is free and the queue can take two commands.
  assign busy   = !front_idle || !q_status.room2;
  assign accept = start && !busy;

  pqed_front #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .request  (request),
    .cfg      (cfg),
    .idle     (front_idle),
    .push     (cmd_push),
    .push_cmd (cmd_in)
  );

  pqed_cmd_fifo u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (cmd_in),
    .pop      (cmd_take),
    .head     (cmd_head),
    .status   (q_status)
  );

  pqed_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!q_status.empty),
    .cmd       (cmd_head),
    .take      (cmd_take),
    .done      (done),
    .result    (result)
  );

`ifndef NO_ASSERTIONS
  // The front end never pushes into a full command queue.
  a_no_cmdq_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !q_status.full)
    else $error("command queue overflow");

  // A transferred item keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("block not busy after a transfer");

  // A pop on an empty ring returns all-zero fields.
  a_empty_pop_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.event_valid) |->
      (result.event_kind == '0) && (result.event_phase == '0) &&
      (result.event_severity == '0) && (result.event_duration_ms == '0) &&
      (result.event_time == '0))
    else $error("empty pop with non-zero fields");

  // Appliance events carry the aggregate phase and no duration; others last 1000 ms.
  a_kind_fields: assert property (@(posedge clk) disable iff (rst)
    (done && result.event_valid) |->
      (((result.event_kind == 3'(pqed_pkg::KIND_ON)) ||
        (result.event_kind == 3'(pqed_pkg::KIND_OFF))) ?
       ((result.event_phase == pqed_pkg::PHASE_AGGREGATE) &&
        (result.event_duration_ms == '0)) :
       (result.event_duration_ms == pqed_pkg::DURATION_QUALITY)))
    else $error("event fields inconsistent with kind");
`endif

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pqed_pkg::*;

  localparam int RING_DEPTH    = 32;
  localparam int CLASS_COUNT   = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_COUNT   = 8;
  localparam int PHASE_ITEMS   = 180;

  // Mirror of the detector: event ring, appliance table and registers.
  // Each pop transfer leaves the result it must produce in pops_awaited.
  class event_log_model;
    result_t     pops_awaited[$];
    result_t     ring[RING_DEPTH];
    int unsigned head;
    int unsigned tail;
    bit          reported[CLASS_COUNT];
    logic [31:0] held_since[CLASS_COUNT];
    cfg_t        cfg;
    int          fault_count;

    function new();
      head = 0;
      tail = 0;
      fault_count = 0;
      foreach (reported[i]) begin
        reported[i] = 1'b0;
        held_since[i] = '0;
      end
      cfg.grid_60hz  = 1'b0;
      cfg.thd_limit  = THD_LIMIT_RESET;
      cfg.pst_limit  = PST_LIMIT_RESET;
      cfg.debounce_s = DEBOUNCE_S_RESET;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] index,
                               logic [CFG_DATA_W-1:0] value);
      case (index)
        CFG_GRID_60HZ:  cfg.grid_60hz  = value[0];
        CFG_THD_LIMIT:  cfg.thd_limit  = value;
        CFG_PST_LIMIT:  cfg.pst_limit  = value;
        CFG_DEBOUNCE_S: cfg.debounce_s = value;
      endcase
    endfunction

    // Appends an event; a full ring loses its oldest entry.
    function void record(kind_t kind, logic [1:0] phase, logic [15:0] severity,
                         logic [31:0] stamp);
      result_t     ev;
      int unsigned next;
      next = (tail + 1) % RING_DEPTH;
      if (next == head) head = (head + 1) % RING_DEPTH;
      ev.event_valid       = 1'b1;
      ev.event_kind        = kind;
      ev.event_phase       = phase;
      ev.event_severity    = severity;
      ev.event_duration_ms = (kind == KIND_ON || kind == KIND_OFF) ? '0 : DURATION_QUALITY;
      ev.event_time        = stamp;
      ring[tail] = ev;
      tail = next;
    endfunction

    // Deviation in truncated hundredths of a percent, saturated to 16 bits.
    function logic [15:0] deviation(int unsigned diff, int unsigned nominal);
      longint unsigned q;
      q = 64'(diff);
      q = q * 10000 / nominal;
      if (q > 65535) return SEVERITY_MAX;
      return q[15:0];
    endfunction

    function void note_request(request_t req);
      int unsigned nominal;
      int unsigned volts;
      logic [31:0] held;
      result_t     popped;
      nominal = cfg.grid_60hz ? 32'(NOM_60HZ_CV) : 32'(NOM_50HZ_CV);
      volts = 32'(req.level_a);
      case (op_t'(req.operation))
        OP_VOLTAGE: begin
          if (req.channel <= PHASE_MAX) begin
            // The voltage event, if any, goes in ahead of the THD event.
            if (volts * 10 < nominal)
              record(KIND_INTERRUPTION, req.channel[1:0], req.level_a, req.timestamp);
            else if (volts * 10 < 9 * nominal)
              record(KIND_SAG, req.channel[1:0], deviation(nominal - volts, nominal),
                     req.timestamp);
            else if (volts * 10 > 11 * nominal)
              record(KIND_SWELL, req.channel[1:0], deviation(volts - nominal, nominal),
                     req.timestamp);
            if (req.level_b > cfg.thd_limit)
              record(KIND_HARMONIC, req.channel[1:0], req.level_b, req.timestamp);
          end
        end
        OP_FLICKER: begin
          if (req.channel <= PHASE_MAX && req.level_a > cfg.pst_limit)
            record(KIND_FLICKER, req.channel[1:0], req.level_a, req.timestamp);
        end
        OP_APPLIANCE: begin
          if (req.channel < CLASS_COUNT) begin
            // A changed state is reported once it has lasted the debounce time;
            // an unchanged state keeps the stamp moving with the clock.
            if (req.appliance_on != reported[req.channel]) begin
              held = req.timestamp - held_since[req.channel];
              if (held >= 32'(cfg.debounce_s)) begin
                record(req.appliance_on ? KIND_ON : KIND_OFF, PHASE_AGGREGATE,
                       req.level_a, req.timestamp);
                reported[req.channel] = req.appliance_on;
                held_since[req.channel] = req.timestamp;
              end
            end else begin
              held_since[req.channel] = req.timestamp;
            end
          end
        end
        OP_POP: begin
          popped = '0;
          if (head != tail) begin
            popped = ring[head];
            head = (head + 1) % RING_DEPTH;
          end
          pops_awaited.push_back(popped);
        end
      endcase
    endfunction

    function string show(result_t r);
      return $sformatf("valid %0b kind %0d phase %0d severity %0d duration %0d time %0h",
                       r.event_valid, r.event_kind, r.event_phase, r.event_severity,
                       r.event_duration_ms, r.event_time);
    endfunction

    function void complain(string what);
      fault_count++;
      if (fault_count <= 10) $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function void check_pop_result(result_t got);
      result_t want;
      if (pops_awaited.size() == 0) begin
        complain($sformatf("result with no pop outstanding: %s", show(got)));
        return;
      end
      want = pops_awaited.pop_front();
      if (got.event_valid !== want.event_valid || got.event_kind !== want.event_kind ||
          got.event_phase !== want.event_phase ||
          got.event_severity !== want.event_severity ||
          got.event_duration_ms !== want.event_duration_ms ||
          got.event_time !== want.event_time)
        complain($sformatf("expected %s, got %s", show(want), show(got)));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   start;
  logic                   busy;
  request_t               request;
  logic                   done;
  result_t                result;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  event_log_model model;
  bit             start_level;
  int             burst_left;
  logic [31:0]    uptime;

  power_quality_event_detector #(
    .QUEUE_DEPTH(RING_DEPTH),
    .NUM_CLASSES(CLASS_COUNT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch every edge for register writes, request transfers and results.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) model.set_register(cfg_index, cfg_data);
      if (done) model.check_pop_result(result);
      if (start && !busy) model.note_request(request);
    end
  end

  function automatic request_t item_of(op_t op, logic [31:0] stamp, logic [5:0] channel,
                                       logic [15:0] level_a, logic [15:0] level_b,
                                       logic on);
    request_t item;
    item.operation    = op;
    item.timestamp    = stamp;
    item.channel      = channel;
    item.level_a      = level_a;
    item.level_b      = level_b;
    item.appliance_on = on;
    return item;
  endfunction

  // A value within spread of centre, clamped to the 16-bit range.
  function automatic logic [15:0] near(int centre, int spread);
    int offset;
    int v;
    offset = int'($urandom_range(0, 2 * spread));
    v = centre + offset - spread;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  // Mostly well-formed items aimed at the thresholds of the current settings,
  // with some ignored channels and full-range values mixed in.
  function automatic request_t random_item(int pop_pct);
    request_t item;
    int       nominal;
    int       pick;
    item.channel      = 6'($urandom_range(0, 63));
    item.level_a      = 16'($urandom);
    item.level_b      = 16'($urandom);
    item.appliance_on = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 59) == 0) uptime = $urandom;
    else if ($urandom_range(0, 3) == 0) uptime = uptime + 1;
    item.timestamp = uptime;
    nominal = model.cfg.grid_60hz ? int'(NOM_60HZ_CV) : int'(NOM_50HZ_CV);
    pick = int'($urandom_range(0, 99));
    if (pick < pop_pct) item.operation = OP_POP;
    else if (pick % 3 == 0) item.operation = OP_VOLTAGE;
    else if (pick % 3 == 1) item.operation = OP_FLICKER;
    else item.operation = OP_APPLIANCE;
    case (op_t'(item.operation))
      OP_VOLTAGE: begin
        if ($urandom_range(0, 9) != 0) item.channel = 6'($urandom_range(0, 2));
        case ($urandom_range(0, 5))
          0: item.level_a = near(nominal / 10, 3);
          1: item.level_a = near(nominal * 9 / 10, 3);
          2: item.level_a = near(nominal * 11 / 10, 3);
          3: item.level_a = near(nominal, 3000);
          4: item.level_a = 16'($urandom_range(0, nominal / 10));
          default: ;
        endcase
        if ($urandom_range(0, 1) == 1) item.level_b = near(int'(model.cfg.thd_limit), 2);
      end
      OP_FLICKER: begin
        if ($urandom_range(0, 9) != 0) item.channel = 6'($urandom_range(0, 2));
        if ($urandom_range(0, 1) == 1) item.level_a = near(int'(model.cfg.pst_limit), 2);
      end
      OP_APPLIANCE: begin
        if ($urandom_range(0, 9) == 0) item.channel = 6'($urandom_range(0, 63));
        else if ($urandom_range(0, 2) == 0)
          item.channel = 6'($urandom_range(0, CLASS_COUNT - 1));
        else item.channel = 6'($urandom_range(0, 3));
      end
      OP_POP: ;
    endcase
    return item;
  endfunction

  // Presents one item and returns at the edge where it is transferred.
  // Start stays high so that a following item can go straight out.
  task automatic send_item(request_t item);
    if (!start_level) start <= 1'b1;
    start_level = 1'b1;
    request <= item;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(int cycles);
    if (start_level) start <= 1'b0;
    start_level = 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Sends in bursts of random length, mostly short, sometimes long.
  task automatic paced_send(request_t item);
    send_item(item);
    burst_left--;
    if (burst_left <= 0) begin
      hold_off(int'($urandom_range(1, 9)));
      burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(30, 80)) :
                                                 int'($urandom_range(1, 12));
    end
  endtask

  // Waits for every outstanding pop, then lets queued events drain.
  task automatic quiesce();
    hold_off(0);
    while (model.pops_awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers on consecutive edges.
  task automatic program_config(cfg_t setting);
    logic [CFG_DATA_W-1:0] values[4];
    values[CFG_GRID_60HZ]  = {15'($urandom), setting.grid_60hz};
    values[CFG_THD_LIMIT]  = setting.thd_limit;
    values[CFG_PST_LIMIT]  = setting.pst_limit;
    values[CFG_DEBOUNCE_S] = setting.debounce_s;
    cfg_we <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= CFG_INDEX_W'(i);
      cfg_data  <= values[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    cfg_t setting;
    int   pop_pct;
    model = new();
    rst       <= 1'b1;
    start     <= 1'b0;
    request   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    start_level = 1'b0;
    burst_left  = 4;
    uptime      = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset settings: 230 V, THD 8%, Pst 1.00, two seconds.
    paced_send(item_of(OP_POP, 32'd0, 6'd0, 16'd0, 16'd0, 1'b0));
    paced_send(item_of(OP_VOLTAGE, 32'd1, 6'd0, 16'd0, 16'd0, 1'b0));
    paced_send(item_of(OP_VOLTAGE, 32'd2, 6'd1, 16'd2299, 16'd801, 1'b0));
    paced_send(item_of(OP_VOLTAGE, 32'd3, 6'd2, 16'd2300, 16'd800, 1'b1));
    paced_send(item_of(OP_VOLTAGE, 32'd4, 6'd2, 16'd25301, 16'hFFFF, 1'b0));
    paced_send(item_of(OP_VOLTAGE, 32'd5, 6'd0, 16'hFFFF, 16'd0, 1'b0));
    paced_send(item_of(OP_VOLTAGE, 32'd6, 6'd3, 16'd0, 16'hFFFF, 1'b0));
    paced_send(item_of(OP_FLICKER, 32'd7, 6'd2, 16'd101, 16'd0, 1'b0));
    paced_send(item_of(OP_APPLIANCE, 32'd11, 6'd15, 16'hFFFF, 16'd0, 1'b1));
    paced_send(item_of(OP_APPLIANCE, 32'd12, 6'd16, 16'd0, 16'd0, 1'b1));
    paced_send(item_of(OP_APPLIANCE, 32'd20, 6'd0, 16'd0, 16'd0, 1'b0));
    paced_send(item_of(OP_APPLIANCE, 32'd21, 6'd0, 16'd5, 16'd0, 1'b1));
    paced_send(item_of(OP_APPLIANCE, 32'd22, 6'd0, 16'd7, 16'd0, 1'b1));
    // The elapsed time wraps past zero here.
    paced_send(item_of(OP_APPLIANCE, 32'd1, 6'd15, 16'd0, 16'd0, 1'b0));
    repeat (12) paced_send(item_of(OP_POP, 32'hFFFF_FFFF, 6'h3F, 16'hFFFF, 16'hFFFF, 1'b1));
    quiesce();

    // Random phases: extreme settings first, then random ones. A low pop rate
    // lets the ring overflow; a high one keeps it near empty.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin
          setting.grid_60hz  = 1'b1;
          setting.thd_limit  = 16'd0;
          setting.pst_limit  = 16'd0;
          setting.debounce_s = 16'd0;
        end
        1: begin
          setting.grid_60hz  = 1'b0;
          setting.thd_limit  = 16'hFFFF;
          setting.pst_limit  = 16'hFFFF;
          setting.debounce_s = 16'hFFFF;
        end
        default: begin
          setting.grid_60hz  = 1'($urandom_range(0, 1));
          setting.thd_limit  = 16'($urandom_range(0, 1500));
          setting.pst_limit  = 16'($urandom_range(0, 300));
          setting.debounce_s = 16'($urandom_range(0, 10));
        end
      endcase
      pop_pct = (p % 3 == 0) ? 8 : ((p % 3 == 1) ? 30 : 55);
      program_config(setting);
      repeat (PHASE_ITEMS) paced_send(random_item(pop_pct));
      quiesce();
    end

    if (model.fault_count == 0) begin
      $display("power_quality_event_detector test passed");
    end else begin
      $display("power_quality_event_detector test failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("power_quality_event_detector test failed");
    $finish;
  end

endmodule
